@@ hw/rtl/ssm_pkg.sv @@
// Shared types, constants and glyph functions for the scrolling marquee.
package ssm_pkg;

   localparam int DIGIT_COUNT_DEFAULT = 4;
   localparam int DIGIT_LINES         = 4;

   localparam logic [7:0] FRAMES_RESET  = 8'd50;
   localparam logic [2:0] OPEN_LENGTH   = 3'd5;
   localparam logic [2:0] CLOSED_LENGTH = 3'd7;
   localparam logic [3:0] ENABLES_NONE  = 4'hF;

   localparam logic [7:0] SEG_BLANK = 8'h00;
   localparam logic [7:0] SEG_O     = 8'h3F;
   localparam logic [7:0] SEG_P     = 8'h73;
   localparam logic [7:0] SEG_E     = 8'h79;
   localparam logic [7:0] SEG_N     = 8'h37;
   localparam logic [7:0] SEG_C     = 8'h39;
   localparam logic [7:0] SEG_L     = 8'h38;
   localparam logic [7:0] SEG_S     = 8'h6D;
   localparam logic [7:0] SEG_D     = 8'h5E;

   typedef enum logic {
      MSG_OPEN   = 1'b0,
      MSG_CLOSED = 1'b1
   } msg_type;

   // What the current tick shows, after any toggle taken on this tick.
   typedef struct packed {
      logic [2:0] scroll_index;
      msg_type    message;
   } tick_view_type;

   function automatic logic [2:0] message_length(input msg_type message);
      return (message == MSG_CLOSED) ? CLOSED_LENGTH : OPEN_LENGTH;
   endfunction

   // The sum is at most 13, so two conditional subtracts bring it below the length.
   function automatic logic [2:0] wrap_position(input logic [3:0] sum, input logic [2:0] len);
      logic [3:0] value;
      value = sum;
      if (value >= {1'b0, len}) value = value - {1'b0, len};
      if (value >= {1'b0, len}) value = value - {1'b0, len};
      return value[2:0];
   endfunction

   function automatic logic [7:0] glyph_lookup(input msg_type message, input logic [2:0] pos);
      logic [7:0] seg;
      seg = SEG_BLANK;
      if (message == MSG_OPEN) begin
         unique case (pos)
            3'd0: seg = SEG_O;
            3'd1: seg = SEG_P;
            3'd2: seg = SEG_E;
            3'd3: seg = SEG_N;
            default: seg = SEG_BLANK;
         endcase
      end else begin
         unique case (pos)
            3'd0: seg = SEG_C;
            3'd1: seg = SEG_L;
            3'd2: seg = SEG_O;
            3'd3: seg = SEG_S;
            3'd4: seg = SEG_E;
            3'd5: seg = SEG_D;
            default: seg = SEG_BLANK;
         endcase
      end
      return seg;
   endfunction

endpackage

@@ hw/rtl/ssm_req_if.sv @@
// Input channel: one tick carrying the button level.
interface ssm_req_if;
   logic valid;
   logic ready;
   logic button_level;

   modport source (output valid, output button_level, input ready);
   modport sink (input valid, input button_level, output ready);
endinterface

@@ hw/rtl/ssm_rsp_if.sv @@
// Result channel: segment pattern, digit enables and message flag for one tick.
interface ssm_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] segment_pattern;
   logic [3:0] digit_enables;
   logic       showing_closed;

   modport source (output valid, output segment_pattern, output digit_enables,
                   output showing_closed, input ready);
   modport sink (input valid, input segment_pattern, input digit_enables,
                 input showing_closed, output ready);
endinterface

@@ hw/rtl/ssm_ctrl.sv @@
// Marquee state: digit, frame and scroll counters, button edge logic, step register.
module ssm_ctrl #(
   parameter int DIGIT_COUNT = ssm_pkg::DIGIT_COUNT_DEFAULT,
   parameter int DIGIT_W     = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  tick_accept,
   input  logic                  button_level,
   input  logic                  csr_write_enable,
   input  logic [7:0]            csr_write_data,
   output logic [DIGIT_W-1:0]    digit_position,
   output ssm_pkg::tick_view_type view
);
   import ssm_pkg::*;

   logic [7:0]         frames_per_step_ff;
   logic [DIGIT_W-1:0] digit_ff, digit_in;
   logic [7:0]         frame_ff, frame_in;
   logic [2:0]         scroll_ff, scroll_in;
   msg_type            msg_ff, msg_in;
   logic               prev_ff, prev_in;
   logic               armed_ff, armed_in;

   logic       sample, rise, fall, toggle, last_digit, step;
   logic [7:0] frame_inc;
   logic [2:0] scroll_now, len;

   always_comb begin
      sample     = (digit_ff == '0) && (frame_ff == '0);
      rise       = button_level && !prev_ff;
      fall       = !button_level && prev_ff;
      toggle     = sample && fall && armed_ff;
      msg_in     = toggle ? msg_type'(~msg_ff) : msg_ff;
      scroll_now = toggle ? 3'd0 : scroll_ff;
      prev_in    = sample ? button_level : prev_ff;
      priority if (sample && rise) armed_in = 1'b1;
      else if (toggle)             armed_in = 1'b0;
      else                         armed_in = armed_ff;

      len        = message_length(msg_in);
      last_digit = (digit_ff == DIGIT_W'(DIGIT_COUNT - 1));
      frame_inc  = frame_ff + 8'd1;
      step       = last_digit && (frame_inc == frames_per_step_ff);
      digit_in   = last_digit ? '0 : digit_ff + DIGIT_W'(1);
      if (last_digit) frame_in = step ? 8'd0 : frame_inc;
      else            frame_in = frame_ff;
      if (step) scroll_in = (scroll_now == len - 3'd1) ? 3'd0 : scroll_now + 3'd1;
      else      scroll_in = scroll_now;
   end

   assign digit_position    = digit_ff;
   assign view.scroll_index = scroll_now;
   assign view.message      = msg_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_per_step_ff <= FRAMES_RESET;
      end else if (csr_write_enable) begin
         frames_per_step_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_ff  <= '0;
         frame_ff  <= '0;
         scroll_ff <= '0;
         msg_ff    <= MSG_OPEN;
         prev_ff   <= 1'b0;
         armed_ff  <= 1'b0;
      end else if (tick_accept) begin
         digit_ff  <= digit_in;
         frame_ff  <= frame_in;
         scroll_ff <= scroll_in;
         msg_ff    <= msg_in;
         prev_ff   <= prev_in;
         armed_ff  <= armed_in;
      end
   end

   // The scroll position always lies inside the message being shown.
   a_scroll_in_range: assert property (@(posedge clock) disable iff (reset)
      scroll_ff < message_length(msg_ff))
      else $error("scroll index beyond message length");

   a_digit_in_range: assert property (@(posedge clock) disable iff (reset)
      32'(digit_ff) < DIGIT_COUNT)
      else $error("digit position beyond digit count");

   // The message only changes on the first tick of a pass.
   a_toggle_on_sample: assert property (@(posedge clock) disable iff (reset)
      !(tick_accept && sample) |=> $stable(msg_ff))
      else $error("message changed outside a sample tick");

endmodule

@@ hw/rtl/ssm_decode.sv @@
// Segment and digit-select decode for the digit being driven this tick.
module ssm_decode #(
   parameter int DIGIT_W = 2
) (
   input  logic [DIGIT_W-1:0]     digit_position,
   input  ssm_pkg::tick_view_type view,
   output logic [7:0]             segment_pattern,
   output logic [3:0]             digit_enables
);
   import ssm_pkg::*;

   logic [3:0] pos_sum;
   logic [2:0] pos;

   always_comb begin
      pos_sum         = {1'b0, view.scroll_index} + 4'(digit_position);
      pos             = wrap_position(pos_sum, message_length(view.message));
      segment_pattern = glyph_lookup(view.message, pos);
      // Digits past the four wired lines select nothing.
      if (32'(digit_position) < DIGIT_LINES) digit_enables = ~(4'b0001 << digit_position);
      else                                   digit_enables = ENABLES_NONE;
   end

endmodule

@@ hw/rtl/scrolling_seven_segment_marquee_unit.sv @@
// Top level of the scrolling seven-segment marquee with its result register.
//
//   channel   direction  payload                                        
//   req_chan  in         button_level[0]                                
//   rsp_chan  out        segment_pattern[7:0] digit_enables[3:0] showing_closed
//   csr       in         csr_write_data[7:0] = frames_per_step          
//
// One tick is accepted per cycle; its result sits in the result register from
// the next cycle on. The input is ready whenever that register is empty or is
// being read in the same cycle, so while a result waits unread no tick is taken.
// Reset clears all counters, selects OPEN and loads a step of 50 frames.
module scrolling_seven_segment_marquee_unit #(
   parameter int DIGIT_COUNT = ssm_pkg::DIGIT_COUNT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   ssm_req_if.sink     req_chan,
   ssm_rsp_if.source   rsp_chan,
   input  logic        csr_write_enable,
   input  logic [7:0]  csr_write_data
);
   import ssm_pkg::*;

   localparam int DIGIT_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;

   logic               accept;
   logic [DIGIT_W-1:0] digit_position;
   tick_view_type      view;
   logic [7:0]         segment_pattern;
   logic [3:0]         digit_enables;

   logic       rsp_valid_ff;
   logic [7:0] rsp_segment_ff;
   logic [3:0] rsp_enables_ff;
   logic       rsp_closed_ff;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   ssm_ctrl #(
      .DIGIT_COUNT(DIGIT_COUNT),
      .DIGIT_W    (DIGIT_W)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .tick_accept     (accept),
      .button_level    (req_chan.button_level),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .digit_position  (digit_position),
      .view            (view)
   );

   ssm_decode #(
      .DIGIT_W(DIGIT_W)
   ) u_decode (
      .digit_position (digit_position),
      .view           (view),
      .segment_pattern(segment_pattern),
      .digit_enables  (digit_enables)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_segment_ff <= segment_pattern;
         rsp_enables_ff <= digit_enables;
         rsp_closed_ff  <= (view.message == MSG_CLOSED);
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.segment_pattern = rsp_segment_ff;
   assign rsp_chan.digit_enables   = rsp_enables_ff;
   assign rsp_chan.showing_closed  = rsp_closed_ff;

   // A held result must block the next tick, or it would be overwritten.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_chan.ready |-> !req_chan.ready)
      else $error("input ready while result register is stalled");

   a_accept_fills: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted tick left no result");

   // At most one digit line is driven low.
   a_one_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $countones(~rsp_enables_ff) <= 1)
      else $error("more than one digit selected");

endmodule

@@ tb/scrolling_seven_segment_marquee_unit_test.sv @@
// Testbench for the scrolling seven-segment marquee: predicts every digit tick and checks it.
module scrolling_seven_segment_marquee_unit_test;
   import ssm_pkg::*;

   typedef struct packed {
      logic [7:0] segments;
      logic [3:0] enables;
      logic       closed;
   } digit_drive_type;

   class marquee_scoreboard_type;
      bit [7:0]        frames_per_step;
      int              digit_pos;
      bit [7:0]        frame_count;
      bit [2:0]        scroll;
      msg_type         message;
      bit              sampled_level;
      bit              armed;
      bit [7:0]        open_glyphs [7];
      bit [7:0]        closed_glyphs [7];
      digit_drive_type expected_drives [$];
      int              failures;

      function new();
         frames_per_step = FRAMES_RESET;
         digit_pos = 0;
         frame_count = '0;
         scroll = '0;
         message = MSG_OPEN;
         sampled_level = 1'b0;
         armed = 1'b0;
         failures = 0;
         open_glyphs = '{SEG_O, SEG_P, SEG_E, SEG_N, SEG_BLANK, SEG_BLANK, SEG_BLANK};
         closed_glyphs = '{SEG_C, SEG_L, SEG_O, SEG_S, SEG_E, SEG_D, SEG_BLANK};
      endfunction

      function void set_frames(input bit [7:0] value);
         frames_per_step = value;
      endfunction

      function int pending();
         return expected_drives.size();
      endfunction

      // Works out what one accepted tick drives onto the display.
      function void note_tick(input bit button);
         digit_drive_type drive;
         int              len;
         int              pos;
         // The button only counts on the first tick of a pass.
         if (digit_pos == 0 && frame_count == 0) begin
            if (button && !sampled_level) begin
               armed = 1'b1;
            end else if (!button && sampled_level && armed) begin
               message = (message == MSG_OPEN) ? MSG_CLOSED : MSG_OPEN;
               scroll = '0;
               armed = 1'b0;
            end
            sampled_level = button;
         end
         len = (message == MSG_CLOSED) ? CLOSED_LENGTH : OPEN_LENGTH;
         pos = (int'(scroll) + digit_pos) % len;
         drive.segments = (message == MSG_CLOSED) ? closed_glyphs[pos] : open_glyphs[pos];
         drive.enables = (digit_pos < DIGIT_LINES) ? ~(4'b0001 << digit_pos) : ENABLES_NONE;
         drive.closed = (message == MSG_CLOSED);
         expected_drives.push_back(drive);
         digit_pos++;
         if (digit_pos >= DIGIT_COUNT_DEFAULT) begin
            digit_pos = 0;
            frame_count = frame_count + 8'd1;
            if (frame_count == frames_per_step) begin
               frame_count = '0;
               scroll = 3'((int'(scroll) + 1) % len);
            end
         end
      endfunction

      function void report(input string what, input int expected, input int actual);
         if (failures < 10)
            $display("%0t: %s: expected %0h, got %0h", $time, what, expected, actual);
         failures++;
      endfunction

      function void check_drive(input logic [7:0] segments, input logic [3:0] enables,
                                input logic closed);
         digit_drive_type want;
         if (expected_drives.size() == 0) begin
            report("result with no tick outstanding", 0, segments);
            return;
         end
         want = expected_drives.pop_front();
         if (segments !== want.segments) report("segment_pattern", want.segments, segments);
         if (enables !== want.enables) report("digit_enables", want.enables, enables);
         if (closed !== want.closed) report("showing_closed", want.closed, closed);
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       csr_write_enable;
   logic [7:0] csr_write_data;

   ssm_req_if req_chan ();
   ssm_rsp_if rsp_chan ();

   scrolling_seven_segment_marquee_unit u_top (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   marquee_scoreboard_type marquee;
   int send_idle_pct  = 28;
   int recv_stall_pct = 51;
   int ticks_sent     = 0;

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_chan.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         marquee.check_drive(rsp_chan.segment_pattern, rsp_chan.digit_enables,
                             rsp_chan.showing_closed);
   end

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic send_tick(input bit level);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.button_level <= level;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      marquee.note_tick(level);
      ticks_sent++;
      // Idling swaps sides after a third of the run and stops after two thirds.
      if (ticks_sent == 533) begin
         send_idle_pct = 51;
         recv_stall_pct = 28;
      end else if (ticks_sent == 1066) begin
         send_idle_pct = 0;
         recv_stall_pct = 0;
      end
      @(negedge clock);
   endtask

   // Button held for random stretches, with an occasional one-tick blip.
   task automatic send_button_runs(input int count, input int longest_run);
      bit level;
      int run_left;
      level = 1'b0;
      run_left = 0;
      for (int i = 0; i < count; i++) begin
         if (run_left == 0) begin
            if ($urandom_range(0, 7) == 0) begin
               level = 1'($urandom_range(0, 1));
               run_left = 1;
            end else begin
               level = ~level;
               run_left = $urandom_range(1, longest_run);
            end
         end
         send_tick(level);
         run_left--;
      end
   endtask

   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (marquee.pending() != 0) @(negedge clock);
      repeat (3) @(negedge clock);
   endtask

   task automatic write_frames(input bit [7:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      marquee.set_frames(value);
   endtask

   initial begin
      bit directed_levels [24];
      directed_levels = '{0, 0, 0, 0, 1, 1, 1, 1, 0, 0, 0, 0,
                          1, 1, 1, 1, 1, 1, 1, 1, 0, 0, 0, 0};
      marquee = new();
      clock = 1'b0;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.button_level = 1'b0;
      rsp_chan.ready = 1'b0;
      csr_write_enable = 1'b0;
      csr_write_data = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // One whole pass at the reset step of 50 frames.
      send_button_runs(200, 300);
      wait_idle();

      // One frame per pass: press, release to CLOSED, hold, release back to OPEN.
      write_frames(8'd1);
      foreach (directed_levels[i]) send_tick(directed_levels[i]);
      send_button_runs(100, 12);
      wait_idle();

      write_frames(8'd2);
      send_button_runs(60, 24);
      wait_idle();

      // Part of a long pass, then the step is lowered below the frame count, to zero.
      write_frames(8'd255);
      send_button_runs(80, 100);
      wait_idle();
      write_frames(8'd0);
      send_button_runs(1040, 400);
      wait_idle();

      write_frames(8'd3);
      send_button_runs(96, 36);
      wait_idle();

      if (marquee.failures == 0 && marquee.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
